// ===== src/linear_keyframe_strip_assert.svh =====
// Assertion helpers shared by the keyframe strip RTL.
`ifndef LINEAR_KEYFRAME_STRIP_ASSERT_SVH
`define LINEAR_KEYFRAME_STRIP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LKFS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkfs assertion failed");

// Next-cycle implication, checked outside reset.
`define LKFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkfs assertion failed");

`endif

// ===== src/lkfs_pkg.sv =====
package lkfs_pkg;

   localparam int MaxSamples      = 65536;
   localparam int CompWidth       = 16;
   localparam int CountWidth      = 16;
   localparam int FlatWidth       = 15;
   localparam int RatioWidth      = 10;
   localparam int CsrIndexWidth   = 2;
   localparam int CsrDataWidth    = 15;
   localparam int QueueDepth      = 8;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [CountWidth-1:0] IndexMax = CountWidth'(MaxSamples - 1);
   localparam logic [CountWidth-1:0] CountMax = '1;

   localparam logic [CsrIndexWidth-1:0] CSR_FLAT_TOLERANCE  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_RATIO_TOLERANCE = 2'd1;

   localparam logic [FlatWidth-1:0]  FlatReset  = 15'd3;
   localparam logic [RatioWidth-1:0] RatioReset = 10'd5;

   typedef struct packed {
      logic signed [CompWidth-1:0] w;
      logic signed [CompWidth-1:0] z;
      logic signed [CompWidth-1:0] y;
      logic signed [CompWidth-1:0] x;
   } sample_type;

   typedef struct packed {
      logic [CountWidth-1:0] index;
      sample_type            sample;
      logic                  last;
   } key_type;

   // Window snapshot of one accepted request
   typedef struct packed {
      logic                  valid;
      logic [CountWidth-1:0] pos;
      logic                  last;
      sample_type            older;
      sample_type            middle;
      sample_type            cur;
   } stage_type;

   // Up to two keys per request, first slot goes out first
   typedef struct packed {
      logic    a_valid;
      key_type a;
      logic    b_valid;
      key_type b;
   } push_type;

   function automatic logic [CountWidth-1:0] clamp_index(input logic [CountWidth-1:0] pos);
      clamp_index = (pos > IndexMax) ? IndexMax : pos;
   endfunction

endpackage

// ===== src/lkfs_lane.sv =====
module lkfs_lane (
   input  logic signed [lkfs_pkg::CompWidth-1:0] lo,
   input  logic signed [lkfs_pkg::CompWidth-1:0] mid,
   input  logic signed [lkfs_pkg::CompWidth-1:0] hi,
   input  logic [lkfs_pkg::FlatWidth-1:0]        flat_tolerance,
   input  logic [lkfs_pkg::RatioWidth-1:0]       ratio_tolerance,
   output logic                                  hit
);

   localparam int DW = lkfs_pkg::CompWidth + 1;
   localparam int EW = lkfs_pkg::CompWidth + 3;
   localparam int PW = EW - 1 + 9;

   logic signed [DW-1:0] diff;
   logic [DW-1:0]        diff_abs_wide;
   logic [DW-2:0]        diff_abs;
   logic signed [EW-1:0] dev;
   logic [EW-1:0]        dev_abs_wide;
   logic [EW-2:0]        dev_abs;
   logic [PW-1:0]        dev_scaled;
   logic [PW-1:0]        allowed;
   logic                 outer_apart;

   // dev = 2*(lo - mid) - (lo - hi) = lo - 2*mid + hi
   assign diff          = DW'(lo) - DW'(hi);
   assign diff_abs_wide = diff[DW-1] ? DW'(-diff) : DW'(diff);
   assign diff_abs      = diff_abs_wide[DW-2:0];
   assign dev           = EW'(lo) - (EW'(mid) <<< 1) + EW'(hi);
   assign dev_abs_wide  = dev[EW-1] ? EW'(-dev) : EW'(dev);
   assign dev_abs       = dev_abs_wide[EW-2:0];
   assign dev_scaled    = {dev_abs, 9'b0};
   assign allowed       = PW'(ratio_tolerance * diff_abs);
   assign outer_apart   = diff_abs > (DW-1)'(flat_tolerance);
   assign hit           = outer_apart && (dev_scaled > allowed);

endmodule

// ===== src/lkfs_merge.sv =====
module lkfs_merge (
   input  lkfs_pkg::stage_type stage,
   input  logic [2:0]          lane_hit,
   output lkfs_pkg::push_type  push
);

   logic                    pos_zero;
   logic                    pos_one;
   logic                    middle_key;
   logic                    final_key;
   lkfs_pkg::sample_type    prev;

   assign pos_zero   = stage.pos == '0;
   assign pos_one    = stage.pos == lkfs_pkg::CountWidth'(1);
   assign middle_key = !pos_zero && !pos_one && (|lane_hit);
   // previous sample is the older one on the second request, else the middle
   assign prev       = pos_one ? stage.older : stage.middle;
   assign final_key  = stage.last && !pos_zero && (stage.cur != prev);

   always_comb begin
      push.a_valid      = stage.valid && (pos_zero || middle_key);
      push.a.index      = pos_zero ? '0 : lkfs_pkg::clamp_index(stage.pos - 1'b1);
      push.a.sample     = pos_zero ? stage.cur : stage.middle;
      push.a.last       = stage.last && !final_key;
      push.b_valid      = stage.valid && final_key;
      push.b.index      = lkfs_pkg::clamp_index(stage.pos);
      push.b.sample     = stage.cur;
      push.b.last       = 1'b1;
   end

endmodule

// ===== src/lkfs_queue.sv =====
module lkfs_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lkfs_pkg::push_type                    push,
   input  logic                                  pop,
   output logic                                  head_valid,
   output lkfs_pkg::key_type                     head,
   output logic [lkfs_pkg::QueueCountWidth-1:0]  count
);

   localparam int PW = lkfs_pkg::QueuePtrWidth;
   localparam int CW = lkfs_pkg::QueueCountWidth;

   lkfs_pkg::key_type entry_ff [lkfs_pkg::QueueDepth];
   logic [PW-1:0]     wr_ff, wr_in;
   logic [PW-1:0]     rd_ff, rd_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push_first;
   logic              push_second;
   lkfs_pkg::key_type first;
   logic [1:0]        push_num;

   assign push_first  = push.a_valid || push.b_valid;
   assign push_second = push.a_valid && push.b_valid;
   assign first       = push.a_valid ? push.a : push.b;
   assign push_num    = {1'b0, push.a_valid} + {1'b0, push.b_valid};

   assign wr_in    = wr_ff + PW'(push_num);
   assign rd_in    = rd_ff + PW'(pop);
   assign count_in = count_ff + CW'(push_num) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         entry_ff[wr_ff] <= first;
      end
      if (push_second) begin
         entry_ff[wr_ff + 1'b1] <= push.b;
      end
   end

   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ff];
   assign count      = count_ff;

endmodule

// ===== src/linear_keyframe_strip.sv =====
// Channel  | Handshake             | Payload
// req      | req_valid, req_stall  | sample x/y/z/w, last_sample
// rsp      | rsp_valid, rsp_stall  | key_index, key x/y/z/w, last_key
// csr      | csr_write_enable      | csr_index, csr_write_data
//
// A request's keys (zero to two) enter the result queue in the cycle after it is
// taken; the single result port drains one key a cycle while rsp_stall is low.
// Requests go in one per cycle while queued keys plus two for a staged request
// stay at six or fewer, so a stream of two-key requests is held back by req_stall.
// Synchronous reset clears the track position, window and queue and loads the
// tolerances with 3 and 5; rsp_stall only holds the queue head.
`include "linear_keyframe_strip_assert.svh"

module linear_keyframe_strip (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [lkfs_pkg::CompWidth-1:0]   req_sample_x,
   input  logic signed [lkfs_pkg::CompWidth-1:0]   req_sample_y,
   input  logic signed [lkfs_pkg::CompWidth-1:0]   req_sample_z,
   input  logic signed [lkfs_pkg::CompWidth-1:0]   req_sample_w,
   input  logic                                    req_last_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [lkfs_pkg::CountWidth-1:0]         rsp_key_index,
   output logic signed [lkfs_pkg::CompWidth-1:0]   rsp_key_x,
   output logic signed [lkfs_pkg::CompWidth-1:0]   rsp_key_y,
   output logic signed [lkfs_pkg::CompWidth-1:0]   rsp_key_z,
   output logic signed [lkfs_pkg::CompWidth-1:0]   rsp_key_w,
   output logic                                    rsp_last_key,
   input  logic                                    csr_write_enable,
   input  logic [lkfs_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [lkfs_pkg::CsrDataWidth-1:0]       csr_write_data
);

   localparam int CW = lkfs_pkg::QueueCountWidth;

   logic [lkfs_pkg::FlatWidth-1:0]  flat_ff, flat_in;
   logic [lkfs_pkg::RatioWidth-1:0] ratio_ff, ratio_in;
   logic [lkfs_pkg::CountWidth-1:0] count_ff, count_in;
   lkfs_pkg::sample_type            older_ff, older_in;
   lkfs_pkg::sample_type            middle_ff, middle_in;
   logic                            stage_valid_ff, stage_valid_in;
   lkfs_pkg::stage_type             stage_ff, stage_in;
   lkfs_pkg::sample_type            cur;
   lkfs_pkg::push_type              push;
   lkfs_pkg::key_type               head;
   logic [CW-1:0]                   queue_count;
   logic [CW:0]                     committed;
   logic [2:0]                      lane_hit;
   logic                            req_accept;
   logic                            rsp_accept;
   lkfs_pkg::stage_type             stage;

   assign cur = '{w: req_sample_w, z: req_sample_z, y: req_sample_y, x: req_sample_x};

   // keys already queued plus two reserved for a valid stage, which pushes up to two next edge
   assign committed  = {1'b0, queue_count} + (stage_valid_ff ? (CW+1)'(2) : '0);
   assign req_stall  = committed > (CW+1)'(lkfs_pkg::QueueDepth - 2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   always_comb begin
      flat_in  = flat_ff;
      ratio_in = ratio_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lkfs_pkg::CSR_FLAT_TOLERANCE:  flat_in  = csr_write_data[lkfs_pkg::FlatWidth-1:0];
            lkfs_pkg::CSR_RATIO_TOLERANCE: ratio_in = csr_write_data[lkfs_pkg::RatioWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in       = count_ff;
      older_in       = older_ff;
      middle_in      = middle_ff;
      stage_valid_in = req_accept;
      stage_in       = '{valid: 1'b1, pos: count_ff, last: req_last_sample,
                         older: older_ff, middle: middle_ff, cur: cur};
      if (req_accept) begin
         // slide the window
         if (count_ff == '0) begin
            older_in = cur;
         end else if (count_ff == lkfs_pkg::CountWidth'(1)) begin
            middle_in = cur;
         end else begin
            older_in  = middle_ff;
            middle_in = cur;
         end
         if (req_last_sample) begin
            count_in = '0;
         end else if (count_ff != lkfs_pkg::CountMax) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flat_ff        <= lkfs_pkg::FlatReset;
         ratio_ff       <= lkfs_pkg::RatioReset;
         count_ff       <= '0;
         older_ff       <= '0;
         middle_ff      <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         flat_ff        <= flat_in;
         ratio_ff       <= ratio_in;
         count_ff       <= count_in;
         older_ff       <= older_in;
         middle_ff      <= middle_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      stage       = stage_ff;
      stage.valid = stage_valid_ff;
   end

   lkfs_lane u_lane_x (
      .lo              (stage_ff.older.x),
      .mid             (stage_ff.middle.x),
      .hi              (stage_ff.cur.x),
      .flat_tolerance  (flat_ff),
      .ratio_tolerance (ratio_ff),
      .hit             (lane_hit[0])
   );

   lkfs_lane u_lane_y (
      .lo              (stage_ff.older.y),
      .mid             (stage_ff.middle.y),
      .hi              (stage_ff.cur.y),
      .flat_tolerance  (flat_ff),
      .ratio_tolerance (ratio_ff),
      .hit             (lane_hit[1])
   );

   lkfs_lane u_lane_z (
      .lo              (stage_ff.older.z),
      .mid             (stage_ff.middle.z),
      .hi              (stage_ff.cur.z),
      .flat_tolerance  (flat_ff),
      .ratio_tolerance (ratio_ff),
      .hit             (lane_hit[2])
   );

   lkfs_merge u_merge (
      .stage    (stage),
      .lane_hit (lane_hit),
      .push     (push)
   );

   lkfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_accept),
      .head_valid (rsp_valid),
      .head       (head),
      .count      (queue_count)
   );

   assign rsp_key_index = head.index;
   assign rsp_key_x     = head.sample.x;
   assign rsp_key_y     = head.sample.y;
   assign rsp_key_z     = head.sample.z;
   assign rsp_key_w     = head.sample.w;
   assign rsp_last_key  = head.last;

   `LKFS_ASSERT_IMPLIES(a_stage_has_room, clock, reset, stage_valid_ff, queue_count <= CW'(lkfs_pkg::QueueDepth - 2))
   `LKFS_ASSERT_NEXT(a_last_restarts_track, clock, reset, req_accept && req_last_sample, count_ff == '0)
   `LKFS_ASSERT_NEXT(a_first_sample_kept, clock, reset, req_accept && count_ff == '0, push.a_valid && push.a.index == '0)

endmodule

// ===== sim/keyframe_checker.sv =====
`timescale 1ns / 100ps

module keyframe_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [lkfs_pkg::CompWidth-1:0]  req_sample_x,
   input  logic signed [lkfs_pkg::CompWidth-1:0]  req_sample_y,
   input  logic signed [lkfs_pkg::CompWidth-1:0]  req_sample_z,
   input  logic signed [lkfs_pkg::CompWidth-1:0]  req_sample_w,
   input  logic                                   req_last_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [lkfs_pkg::CountWidth-1:0]        rsp_key_index,
   input  logic signed [lkfs_pkg::CompWidth-1:0]  rsp_key_x,
   input  logic signed [lkfs_pkg::CompWidth-1:0]  rsp_key_y,
   input  logic signed [lkfs_pkg::CompWidth-1:0]  rsp_key_z,
   input  logic signed [lkfs_pkg::CompWidth-1:0]  rsp_key_w,
   input  logic                                   rsp_last_key,
   input  logic                                   csr_write_enable,
   input  logic [lkfs_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [lkfs_pkg::CsrDataWidth-1:0]      csr_write_data,
   output int                                     mismatch_count,
   output int                                     keys_outstanding
);

   localparam int ReportLimit = 10;

   lkfs_pkg::key_type    pending_keys[$];
   lkfs_pkg::sample_type older_s;
   lkfs_pkg::sample_type middle_s;
   lkfs_pkg::sample_type arriving;
   logic [14:0]          flat_tol;
   logic [9:0]           ratio_tol;
   logic [15:0]          track_pos;
   int                   errors = 0;

   // True when some of x/y/z moves across the window and the middle is off the line
   function automatic bit middle_bends(input lkfs_pkg::sample_type lo,
                                       input lkfs_pkg::sample_type mid,
                                       input lkfs_pkg::sample_type hi);
      longint a[3];
      longint m[3];
      longint b[3];
      longint d;
      longint ad;
      longint e;
      longint ae;
      bit     bent;
      a[0] = lo.x;  a[1] = lo.y;  a[2] = lo.z;
      m[0] = mid.x; m[1] = mid.y; m[2] = mid.z;
      b[0] = hi.x;  b[1] = hi.y;  b[2] = hi.z;
      bent = 1'b0;
      for (int p = 0; p < 3; p++) begin
         d  = a[p] - b[p];
         ad = (d < 0) ? -d : d;
         if (ad > longint'(flat_tol)) begin
            e  = 2 * (a[p] - m[p]) - d;
            ae = (e < 0) ? -e : e;
            if (512 * ae > longint'(ratio_tol) * ad)
               bent = 1'b1;
         end
      end
      return bent;
   endfunction

   function automatic lkfs_pkg::key_type make_key(input logic [15:0] pos,
                                                  input lkfs_pkg::sample_type s);
      lkfs_pkg::key_type k;
      // the position counter saturates at the index ceiling, so no clamp is needed
      k.index  = pos;
      k.sample = s;
      k.last   = 1'b0;
      return k;
   endfunction

   task automatic take_sample(input lkfs_pkg::sample_type cur, input logic ends_track);
      lkfs_pkg::key_type made[$];
      logic [15:0]       pos;
      pos = track_pos;
      if (pos == 16'd0) begin
         made = {made, make_key(16'd0, cur)};
         older_s = cur;
      end else if (pos == 16'd1) begin
         middle_s = cur;
      end else begin
         if (middle_bends(older_s, middle_s, cur))
            made = {made, make_key(pos - 16'd1, middle_s)};
         older_s  = middle_s;
         middle_s = cur;
      end
      if (ends_track) begin
         if (pos != 16'd0 && middle_s != older_s)
            made = {made, make_key(pos, middle_s)};
         if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
         track_pos = 16'd0;
      end else if (pos != 16'hFFFF) begin
         track_pos = pos + 16'd1;
      end
      pending_keys = {pending_keys, made};
   endtask

   task automatic compare_key();
      lkfs_pkg::key_type seen;
      lkfs_pkg::key_type want;
      seen.index    = rsp_key_index;
      seen.sample.x = rsp_key_x;
      seen.sample.y = rsp_key_y;
      seen.sample.z = rsp_key_z;
      seen.sample.w = rsp_key_w;
      seen.last     = rsp_last_key;
      if (pending_keys.size() == 0) begin
         errors++;
         if (errors <= ReportLimit)
            $display("%t: key with nothing pending: index %0d x %0d y %0d z %0d w %0d last %0b",
                     $realtime, seen.index, seen.sample.x, seen.sample.y, seen.sample.z,
                     seen.sample.w, seen.last);
      end else begin
         want = pending_keys.pop_front();
         if (seen.index !== want.index || seen.sample.x !== want.sample.x ||
             seen.sample.y !== want.sample.y || seen.sample.z !== want.sample.z ||
             seen.sample.w !== want.sample.w || seen.last !== want.last) begin
            errors++;
            if (errors <= ReportLimit) begin
               $display("%t: key mismatch (expected / actual)", $realtime);
               $display("   index %0d / %0d  last %0b / %0b", want.index, seen.index,
                        want.last, seen.last);
               $display("   x %0d / %0d  y %0d / %0d", want.sample.x, seen.sample.x,
                        want.sample.y, seen.sample.y);
               $display("   z %0d / %0d  w %0d / %0d", want.sample.z, seen.sample.z,
                        want.sample.w, seen.sample.w);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         flat_tol  = 15'd3;
         ratio_tol = 10'd5;
         track_pos = 16'd0;
         older_s   = '0;
         middle_s  = '0;
         pending_keys.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_key();
         if (req_valid && !req_stall) begin
            arriving.x = req_sample_x;
            arriving.y = req_sample_y;
            arriving.z = req_sample_z;
            arriving.w = req_sample_w;
            take_sample(arriving, req_last_sample);
         end
         if (csr_write_enable) begin
            case (csr_index)
               lkfs_pkg::CSR_FLAT_TOLERANCE:  flat_tol  = csr_write_data[14:0];
               lkfs_pkg::CSR_RATIO_TOLERANCE: ratio_tol = csr_write_data[9:0];
               default: ;
            endcase
         end
      end
      mismatch_count   <= errors;
      keys_outstanding <= pending_keys.size();
   end

endmodule

// ===== sim/linear_keyframe_strip_tb.sv =====
`timescale 1ns / 100ps

module linear_keyframe_strip_tb;

   localparam int IdleLimit    = 2000;
   localparam int SettleCycles = 4;

   localparam logic [lkfs_pkg::CsrIndexWidth-1:0] CsrUnmappedLow  = 2'd2;
   localparam logic [lkfs_pkg::CsrIndexWidth-1:0] CsrUnmappedHigh = 2'd3;

   typedef enum int {TRACK_NOISE, TRACK_RAMP, TRACK_HOLD, TRACK_EXTREME} track_style_type;

   logic                                   clock;
   logic                                   reset            = 1'b1;
   logic                                   req_valid        = 1'b0;
   logic                                   req_stall;
   logic signed [lkfs_pkg::CompWidth-1:0]  req_sample_x     = '0;
   logic signed [lkfs_pkg::CompWidth-1:0]  req_sample_y     = '0;
   logic signed [lkfs_pkg::CompWidth-1:0]  req_sample_z     = '0;
   logic signed [lkfs_pkg::CompWidth-1:0]  req_sample_w     = '0;
   logic                                   req_last_sample  = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_stall        = 1'b0;
   logic [lkfs_pkg::CountWidth-1:0]        rsp_key_index;
   logic signed [lkfs_pkg::CompWidth-1:0]  rsp_key_x;
   logic signed [lkfs_pkg::CompWidth-1:0]  rsp_key_y;
   logic signed [lkfs_pkg::CompWidth-1:0]  rsp_key_z;
   logic signed [lkfs_pkg::CompWidth-1:0]  rsp_key_w;
   logic                                   rsp_last_key;
   logic                                   csr_write_enable = 1'b0;
   logic [lkfs_pkg::CsrIndexWidth-1:0]     csr_index        = '0;
   logic [lkfs_pkg::CsrDataWidth-1:0]      csr_write_data   = '0;

   int mismatch_count;
   int keys_outstanding;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;

   linear_keyframe_strip u_dut (.*);

   keyframe_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic lkfs_pkg::sample_type pack4(input int x, input int y,
                                                  input int z, input int w);
      lkfs_pkg::sample_type s;
      s.x = x[15:0];
      s.y = y[15:0];
      s.z = z[15:0];
      s.w = w[15:0];
      return s;
   endfunction

   task automatic send_sample(input lkfs_pkg::sample_type s, input logic ends_track);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_x    <= s.x;
      req_sample_y    <= s.y;
      req_sample_z    <= s.z;
      req_sample_w    <= s.w;
      req_last_sample <= ends_track;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold until every pending key has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (keys_outstanding != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [lkfs_pkg::CsrIndexWidth-1:0] idx,
                                 input logic [lkfs_pkg::CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_track(input int len, input track_style_type style);
      int base[4];
      int slope[4];
      int v[4];
      logic ends_track;
      for (int c = 0; c < 4; c++) begin
         base[c]  = $urandom_range(0, 65535) - 32768;
         slope[c] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8000) - 4000
                                                : $urandom_range(0, 400) - 200;
         v[c]     = base[c];
      end
      for (int i = 0; i < len; i++) begin
         for (int c = 0; c < 4; c++) begin
            case (style)
               TRACK_NOISE: v[c] = $urandom_range(0, 65535);
               // jitter of a couple of counts sits near the ratio tolerance
               TRACK_RAMP:  v[c] = base[c] + slope[c] * i + $urandom_range(0, 4) - 2;
               TRACK_HOLD: begin
                  if ($urandom_range(0, 1) == 0)
                     v[c] = v[c] + $urandom_range(0, 16) - 8;
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0:       v[c] = -32768;
                     1:       v[c] = 32767;
                     2:       v[c] = 0;
                     3:       v[c] = -1;
                     default: v[c] = $urandom_range(0, 65535);
                  endcase
               end
            endcase
         end
         // now and then cut a track short
         ends_track = (i == len - 1) || ($urandom_range(0, 49) == 0);
         send_sample(pack4(v[0], v[1], v[2], v[3]), ends_track);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
      int sent;
      int len;
      sent               = 0;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      while (sent < items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         run_track(len, track_style_type'($urandom_range(0, 3)));
         sent += len;
         if ($urandom_range(0, 19) == 0)
            wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unmapped register indexes must leave both tolerances alone
      write_register(CsrUnmappedLow, 15'h0000);
      write_register(CsrUnmappedHigh, 15'h7FFF);

      // single-sample track
      send_sample(pack4(-32768, 32767, -1, 0), 1'b1);
      // full-scale swing, then a final sample that differs only in w
      send_sample(pack4(-32768, -32768, -32768, -32768), 1'b0);
      send_sample(pack4(32767, 32767, 32767, 32767), 1'b0);
      send_sample(pack4(32767, 32767, 32767, -32768), 1'b1);
      // middles just inside and just outside the ratio tolerance
      send_sample(pack4(0, 0, 0, 0), 1'b0);
      send_sample(pack4(517, 0, 0, 0), 1'b0);
      send_sample(pack4(1024, 0, 0, 0), 1'b0);
      send_sample(pack4(1542, 0, 0, 0), 1'b1);
      // outer pair exactly at the flat tolerance
      send_sample(pack4(0, 0, 0, 0), 1'b0);
      send_sample(pack4(50, -50, 9, 1), 1'b0);
      send_sample(pack4(3, -3, -3, 1), 1'b1);
      // track ending on a repeat: the end is carried by no key
      send_sample(pack4(1234, -99, 7, 5), 1'b0);
      send_sample(pack4(1234, -99, 7, 5), 1'b0);
      send_sample(pack4(1234, -99, 7, 5), 1'b1);
      send_sample(pack4(-5, 6, -7, 8), 1'b0);
      send_sample(pack4(-5, 6, -7, 8), 1'b1);
      // two-sample track with a differing end
      send_sample(pack4(100, 200, 300, 400), 1'b0);
      send_sample(pack4(100, 200, 300, 401), 1'b1);
      wait_drained();

      write_register(lkfs_pkg::CSR_FLAT_TOLERANCE, 15'd0);
      write_register(lkfs_pkg::CSR_RATIO_TOLERANCE, 15'd0);
      run_phase(0, 0, 350);

      write_register(lkfs_pkg::CSR_FLAT_TOLERANCE, 15'h7FFF);
      write_register(lkfs_pkg::CSR_RATIO_TOLERANCE, 15'h7FFF);
      run_phase(80, 0, 350);

      write_register(lkfs_pkg::CSR_FLAT_TOLERANCE, 15'($urandom_range(0, 64)));
      write_register(lkfs_pkg::CSR_RATIO_TOLERANCE, 15'($urandom_range(0, 1023)));
      run_phase(0, 80, 350);

      write_register(lkfs_pkg::CSR_FLAT_TOLERANCE, 15'($urandom_range(0, 32767)));
      write_register(lkfs_pkg::CSR_RATIO_TOLERANCE, 15'($urandom_range(0, 32767)));
      run_phase(27, 27, 350);

      write_register(lkfs_pkg::CSR_FLAT_TOLERANCE, 15'($urandom_range(0, 200)));
      write_register(lkfs_pkg::CSR_RATIO_TOLERANCE, 15'($urandom_range(0, 40)));
      run_phase(0, 0, 350);

      repeat (4 * SettleCycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/lkfs_pkg.sv
src/lkfs_lane.sv
src/lkfs_merge.sv
src/lkfs_queue.sv
src/linear_keyframe_strip.sv
sim/keyframe_checker.sv
sim/linear_keyframe_strip_tb.sv
